// ----- hw/rtl/rectangle_union_area_assert.svh -----
// Assertion macros used by the checker file rua_checker.sv.
`ifndef RECTANGLE_UNION_AREA_ASSERT_SVH
`define RECTANGLE_UNION_AREA_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define RUA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rectangle union area check failed");

// Next-cycle implication, disabled while reset is held
`define RUA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rectangle union area check failed");

`endif

// ----- hw/rtl/rua_pkg.sv -----
package rua_pkg;

	localparam int MAX_RECTS = 1024;
	localparam int COORD_W   = 17;
	localparam int CNT_W     = $clog2(MAX_RECTS + 1);
	localparam int ADDR_W    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int RECT_W    = 4 * COORD_W;
	localparam int AREA_W    = 34;
	localparam int ROUND_W   = 27;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int DIV_W     = AREA_W + 1;
	localparam int WAIT_W    = CNT_W + 1;
	localparam int RECIP_W   = 32;
	localparam int RECIP_SH  = 36;
	localparam int QUOT_W    = 2 * RECIP_W - RECIP_SH;

	localparam logic [DIV_W-1:0]     ROUND_HALF = DIV_W'(50);
	localparam logic [ROUND_W-1:0]   ROUND_MAX  = '1;
	// floor(x / 25) equals (x * RECIP_25) >> RECIP_SH for every 32-bit x
	localparam logic [RECIP_W-1:0]   RECIP_25   = 32'd2748779070;

	typedef struct packed {
		logic [COORD_W-1:0] x_low;
		logic [COORD_W-1:0] y_low;
		logic [COORD_W-1:0] x_high;
		logic [COORD_W-1:0] y_high;
	} rua_rect_t;

	// One y interval travelling through the sorting chain
	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] lo;
		logic [COORD_W-1:0] hi;
	} rua_iv_t;

	typedef struct packed {
		logic shift;
	} rua_chain_ctl_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_SETTLE,
		ST_DRAIN,
		ST_MUL,
		ST_ACC,
		ST_DIV,
		ST_DONE
	} rua_state_t;

endpackage

// ----- hw/rtl/rua_ifs.sv -----
interface rua_rect_if;
	logic                        valid;
	logic                        ready;
	logic [rua_pkg::COORD_W-1:0] x_low;
	logic [rua_pkg::COORD_W-1:0] y_low;
	logic [rua_pkg::COORD_W-1:0] x_high;
	logic [rua_pkg::COORD_W-1:0] y_high;
	logic                        last_rect;

	modport source (output valid, x_low, y_low, x_high, y_high, last_rect, input ready);
	modport sink (input valid, x_low, y_low, x_high, y_high, last_rect, output ready);
endinterface

interface rua_area_if;
	logic                        valid;
	logic                        ready;
	logic [rua_pkg::AREA_W-1:0]  area_exact;
	logic [rua_pkg::ROUND_W-1:0] area_rounded;
	logic                        overflow;

	modport source (output valid, area_exact, area_rounded, overflow, input ready);
	modport sink (input valid, area_exact, area_rounded, overflow, output ready);
endinterface

// ----- hw/rtl/rua_ram.sv -----
module rua_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- hw/rtl/rua_cell.sv -----
module rua_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rua_pkg::rua_chain_ctl_t ctl,
	input  rua_pkg::rua_iv_t        left_in,
	input  rua_pkg::rua_iv_t        right_st,
	output rua_pkg::rua_iv_t        st,
	output rua_pkg::rua_iv_t        pass
);
	import rua_pkg::*;

	rua_iv_t st_q;
	rua_iv_t pass_q;

	// Keep the interval with the lower bottom, hand the other one right;
	// in drain mode take the right neighbor's interval
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.valid   <= 1'b0;
			pass_q.valid <= 1'b0;
		end else if (ctl.shift) begin
			st_q         <= right_st;
			pass_q.valid <= 1'b0;
		end else if (!left_in.valid) begin
			pass_q.valid <= 1'b0;
		end else if (!st_q.valid) begin
			st_q         <= left_in;
			pass_q.valid <= 1'b0;
		end else if (left_in.lo < st_q.lo) begin
			st_q   <= left_in;
			pass_q <= st_q;
		end else begin
			pass_q <= left_in;
		end
	end

	assign st   = st_q;
	assign pass = pass_q;
endmodule

// ----- hw/rtl/rua_chain.sv -----
module rua_chain (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rua_pkg::rua_chain_ctl_t ctl,
	input  rua_pkg::rua_iv_t        ins,
	output rua_pkg::rua_iv_t        head
);
	import rua_pkg::*;

	rua_iv_t st_w    [MAX_RECTS];
	rua_iv_t pass_w  [MAX_RECTS];
	rua_iv_t left_w  [MAX_RECTS];
	rua_iv_t right_w [MAX_RECTS];

	// Row of sorting cells, lowest bottom edge settles in cell zero
	for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_w[i] = ins;
		end else begin : g_mid
			assign left_w[i] = pass_w[i-1];
		end
		if (i == MAX_RECTS - 1) begin : g_end
			assign right_w[i] = '0;
		end else begin : g_inner
			assign right_w[i] = st_w[i+1];
		end

		rua_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.left_in  (left_w[i]),
			.right_st (right_w[i]),
			.st       (st_w[i]),
			.pass     (pass_w[i])
		);
	end

	assign head = st_w[0];
endmodule

// ----- hw/rtl/rectangle_union_area.sv -----
// Channel | Dir | Fields                                   | Request
// rect    | in  | x_low y_low x_high y_high last_rect      | one rectangle
// area    | out | area_exact area_rounded overflow         | one result per set
//
// Loading takes one rectangle per cycle, through the rectangle memory write port.
// Each x slab runs a memory scan of the n stored rectangles, a chain settle, a drain of the
// intervals fed to the chain and a multiply-accumulate; up to 2n + 1 slabs.
// Rounding adds 50, drops two bits, then multiplies by the reciprocal of 25.
// Reset clears control only; memory contents are undefined and never read before written.
// Rectangles are taken only while loading; a waiting result does not stop loading the next set.
module rectangle_union_area (
	input  logic clk,
	input  logic arst_n,
	rua_rect_if.sink   rect,
	rua_area_if.source area
);
	import rua_pkg::*;

	rua_state_t           state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;
	logic                 ovf_q;
	logic [CNT_W-1:0]     rd_addr_q;
	logic                 rd_valid_s1;
	logic [COORD_W-1:0]   cur_x_q, nxt_x_q;
	logic                 nxt_found_q;
	logic [CNT_W-1:0]     fed_q;
	logic [WAIT_W-1:0]    wait_q;
	logic [COORD_W-1:0]   len_q, end_q;
	logic [PROD_W-1:0]    prod_s1;
	logic [AREA_W-1:0]    area_q;
	logic [DIV_W-1:0]     div_num_q;
	logic [2*RECIP_W-1:0] div_prod_q;
	logic                 out_valid_q;
	logic [AREA_W-1:0]    out_exact_q;
	logic [ROUND_W-1:0]   out_round_q;
	logic                 out_ovf_q;

	logic                 in_acc, room, scan_start;
	rua_rect_t            wr_rect, rd_rect;
	logic [RECT_W-1:0]    rd_data;
	logic                 c_lo_ok, c_hi_ok, c_any, active;
	logic [COORD_W-1:0]   c_min;
	rua_iv_t              ins, head;
	rua_chain_ctl_t       ctl;
	logic [COORD_W-1:0]   eff_lo;
	logic [QUOT_W-1:0]    div_quot;
	logic [COORD_W-1:0]   dx;

	assign in_acc     = rect.valid && rect.ready;
	assign rect.ready = (state_q == ST_LOAD);
	assign room       = (cnt_q < CNT_W'(MAX_RECTS));

	// Store an inverted rectangle as an empty one
	always_comb begin
		if ((rect.x_high < rect.x_low) || (rect.y_high < rect.y_low)) begin
			wr_rect = '0;
		end else begin
			wr_rect.x_low  = rect.x_low;
			wr_rect.y_low  = rect.y_low;
			wr_rect.x_high = rect.x_high;
			wr_rect.y_high = rect.y_high;
		end
	end

	rua_ram #(
		.WIDTH (RECT_W),
		.DEPTH (MAX_RECTS)
	) u_rect_ram (
		.clk   (clk),
		.we    (in_acc && room),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (wr_rect),
		.raddr (rd_addr_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);
	assign rd_rect = rd_data;

	// Next slab edge candidate and activity test for the scanned rectangle
	always_comb begin
		c_lo_ok = rd_rect.x_low > cur_x_q;
		c_hi_ok = rd_rect.x_high > cur_x_q;
		c_any   = c_lo_ok || c_hi_ok;
		if (c_lo_ok && c_hi_ok) begin
			c_min = (rd_rect.x_low < rd_rect.x_high) ? rd_rect.x_low : rd_rect.x_high;
		end else if (c_lo_ok) begin
			c_min = rd_rect.x_low;
		end else begin
			c_min = rd_rect.x_high;
		end
		active    = (rd_rect.x_low <= cur_x_q) && (cur_x_q < rd_rect.x_high);
		ins.valid = rd_valid_s1 && active && (rd_rect.y_low < rd_rect.y_high);
		ins.lo    = rd_rect.y_low;
		ins.hi    = rd_rect.y_high;
	end

	assign ctl.shift = (state_q == ST_DRAIN);

	rua_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.ins    (ins),
		.head   (head)
	);

	assign eff_lo   = (head.lo > end_q) ? head.lo : end_q;
	assign dx       = nxt_x_q - cur_x_q;
	assign div_quot = div_prod_q[2*RECIP_W-1:RECIP_SH];

	// Next state
	always_comb begin
		state_d    = state_q;
		scan_start = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && rect.last_rect) begin
					state_d    = ST_SCAN;
					scan_start = 1'b1;
				end
			end
			ST_SCAN: begin
				if ((rd_addr_q == cnt_q) && !rd_valid_s1) begin
					state_d = ST_SETTLE;
				end
			end
			ST_SETTLE: begin
				if (wait_q >= ({1'b0, fed_q} + WAIT_W'(2))) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!head.valid) begin
					state_d = nxt_found_q ? ST_MUL : ST_DIV;
				end
			end
			ST_MUL: state_d = ST_ACC;
			ST_ACC: begin
				state_d    = ST_SCAN;
				scan_start = 1'b1;
			end
			ST_DIV: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Set bookkeeping: count, overflow, area
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			area_q <= '0;
		end else if (state_q == ST_DONE && !out_valid_q) begin
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			area_q <= '0;
		end else begin
			if (in_acc) begin
				if (room) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == ST_ACC) begin
				area_q <= area_q + prod_s1;
			end
		end
	end

	// Scan read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q   <= '0;
			rd_valid_s1 <= 1'b0;
		end else if (scan_start) begin
			rd_addr_q   <= '0;
			rd_valid_s1 <= 1'b0;
		end else if (state_q == ST_SCAN && rd_addr_q < cnt_q) begin
			rd_addr_q   <= rd_addr_q + CNT_W'(1);
			rd_valid_s1 <= 1'b1;
		end else begin
			rd_valid_s1 <= 1'b0;
		end
	end

	// Slab edges, fed count, settle timer and covered length
	always_ff @(posedge clk) begin
		if (scan_start) begin
			cur_x_q     <= (state_q == ST_ACC) ? nxt_x_q : '0;
			nxt_found_q <= 1'b0;
			fed_q       <= '0;
			wait_q      <= '0;
			len_q       <= '0;
			end_q       <= '0;
		end else begin
			if (rd_valid_s1 && c_any && (!nxt_found_q || c_min < nxt_x_q)) begin
				nxt_x_q     <= c_min;
				nxt_found_q <= 1'b1;
			end
			if (ins.valid) begin
				fed_q <= fed_q + CNT_W'(1);
			end
			if (state_q == ST_SETTLE) begin
				wait_q <= wait_q + WAIT_W'(1);
			end
			// Add the part of each sorted interval beyond the covered end
			if (state_q == ST_DRAIN && head.valid && head.hi > end_q) begin
				len_q <= len_q + (head.hi - eff_lo);
				end_q <= head.hi;
			end
		end
		if (state_q == ST_MUL) begin
			prod_s1 <= PROD_W'(len_q) * PROD_W'(dx);
		end
	end

	// Divide by 100 with rounding: add 50, drop two bits, then scale by the reciprocal of 25
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN) begin
			div_num_q <= {1'b0, area_q} + ROUND_HALF;
		end
		if (state_q == ST_DIV) begin
			div_prod_q <= (2 * RECIP_W)'(div_num_q[RECIP_W+1:2]) * (2 * RECIP_W)'(RECIP_25);
		end
	end

	// Result register, held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && !out_valid_q) begin
			out_valid_q <= 1'b1;
		end else if (area.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Saturate the rounded area when the top numerator bit or the quotient overflows
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && !out_valid_q) begin
			out_exact_q <= area_q;
			out_round_q <= (div_num_q[DIV_W-1] || (div_quot > QUOT_W'(ROUND_MAX))) ? ROUND_MAX
				: div_quot[ROUND_W-1:0];
			out_ovf_q   <= ovf_q;
		end
	end

	assign area.valid        = out_valid_q;
	assign area.area_exact   = out_exact_q;
	assign area.area_rounded = out_round_q;
	assign area.overflow     = out_ovf_q;
endmodule

// ----- hw/rtl/rua_checker.sv -----
`include "rectangle_union_area_assert.svh"

module rua_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        in_last,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [rua_pkg::AREA_W-1:0]  area_exact,
	input logic [rua_pkg::ROUND_W-1:0] area_rounded
);
	import rua_pkg::*;

	// A waiting result stays offered
	`RUA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// One result per set: a taken result is not followed at once by another
	`RUA_ASSERT_NXT(a_single_result, clk, arst_n, out_valid && out_ready, !out_valid)
	// Closing a set stops loading while the sweep runs
	`RUA_ASSERT_NXT(a_busy_after_last, clk, arst_n, in_valid && in_ready && in_last, !in_ready)
	// Rounded hundredths never exceed a quarter of the exact ten-thousandths
	`RUA_ASSERT_IMP(a_round_bound, clk, arst_n, out_valid,
		{{(AREA_W - 2 - ROUND_W){1'b0}}, area_rounded} <= area_exact[AREA_W-1:2])
endmodule

bind rectangle_union_area rua_checker u_rua_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (rect.valid),
	.in_ready     (rect.ready),
	.in_last      (rect.last_rect),
	.out_valid    (area.valid),
	.out_ready    (area.ready),
	.area_exact   (area.area_exact),
	.area_rounded (area.area_rounded)
);
